FILE: hdl/u8dec_pkg.sv
// shared types, constants and decode helpers for the utf8 code point decoder
package u8dec_pkg;

  localparam int unsigned RES_MAX   = 3;
  localparam int unsigned QUEUE_DEP = 4;

  localparam logic [20:0] SUB_CHAR = 21'h00003F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        substituted;
    logic        run_end;
    logic        text_end;
  } out_t;

  typedef out_t [RES_MAX-1:0] res_vec_t;

  // sequence length announced by a lead byte, 0 when it cannot lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd1:    cp = {13'd0, b0};
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

endpackage

FILE: hdl/utf8_codepoint_decoder_unit.sv
// top level of the permissive utf8 code point decoder
//
// in_ channel: one text byte per request, final_byte marks the last byte of
// a text. out_ channel: one code point per request with substitution,
// run_end (last result of its byte) and text_end (last result of the text).
// a byte that completes a sequence or is an invalid lead gives one result,
// a byte inside a sequence gives none, and the final byte gives one to three.
// an accepted byte is held in the input register, decoded combinationally
// and pushed into the four-entry result queue, whose head drives out_.
// throughput: one byte per cycle while the queue has space for its results;
// the extra results of a final byte drain one per cycle while later bytes
// keep entering as long as the queue has space for their results.
// reset (rst_n low, synchronous) empties the input register, the queue and
// any held partial sequence.
// when the receiver stalls, results wait in the queue; once it cannot take
// the results of the registered byte, in_ready drops until it drains.
module utf8_codepoint_decoder_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  u8dec_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output u8dec_pkg::out_t out_data
);

  logic                in_vld_r;
  u8dec_pkg::in_t      in_item_r;
  logic                commit;
  logic                room;
  logic [1:0]          res_cnt;
  u8dec_pkg::res_vec_t res;

  assign commit   = in_vld_r && room;
  assign in_ready = !in_vld_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (commit) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  u8dec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (in_item_r),
    .commit  (commit),
    .res_cnt (res_cnt),
    .res     (res)
  );

  u8dec_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (commit),
    .push_cnt  (res_cnt),
    .push_res  (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a byte that is not final gives at most one result
  assert property (@(posedge clk) disable iff (!rst_n)
    commit && !in_item_r.final_byte |-> res_cnt <= 2'd1)
    else $error("non-final byte produced more than one result");

  // the final byte always releases at least one result
  assert property (@(posedge clk) disable iff (!rst_n)
    commit && in_item_r.final_byte |-> res_cnt != 2'd0)
    else $error("final byte produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_end |-> out_data.run_end)
    else $error("text end without run end");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_vld_r)
    else $error("pipeline not empty after reset");
`endif

endmodule

FILE: hdl/u8dec_core.sv
// decode of one registered byte against the held partial sequence
module u8dec_core (
  input  logic                clk,
  input  logic                rst_n,
  input  u8dec_pkg::in_t      item,
  input  logic                commit,
  output logic [1:0]          res_cnt,
  output u8dec_pkg::res_vec_t res
);

  logic [7:0] pend_bytes_r [0:2];
  logic [1:0] pend_cnt_r;
  logic [1:0] pend_cnt_nxt;
  logic [2:0] seq_len_r;
  logic [2:0] seq_len_nxt;
  logic       hold;

  logic [7:0] buf_b [0:3];
  logic [2:0] n;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 3 && 2'(i) < pend_cnt_r) begin
        buf_b[i] = pend_bytes_r[i];
      end else begin
        buf_b[i] = item.text_byte;
      end
    end
  end

  assign n = {1'b0, pend_cnt_r} + 3'd1;

  always_comb begin
    logic [2:0] pos;
    logic [2:0] len;
    logic [1:0] k;
    logic [1:0] p;
    res          = '0;
    k            = 2'd0;
    hold         = 1'b0;
    pend_cnt_nxt = 2'd0;
    seq_len_nxt  = 3'd0;
    pos          = 3'd0;
    len          = 3'd0;
    p            = 2'd0;
    if (!item.final_byte) begin
      len = (pend_cnt_r == 2'd0) ? u8dec_pkg::lead_length(item.text_byte) : seq_len_r;
      if (len == 3'd0) begin
        res[0].code_point  = u8dec_pkg::SUB_CHAR;
        res[0].substituted = 1'b1;
        k = 2'd1;
      end else if (len <= n) begin
        res[0].code_point = u8dec_pkg::assemble(buf_b[0], buf_b[1], buf_b[2], buf_b[3], len);
        k = 2'd1;
      end else begin
        hold         = 1'b1;
        pend_cnt_nxt = n[1:0];
        seq_len_nxt  = len;
      end
    end else begin
      // truncated lead gives '?' and the bytes behind it are retried as leads
      for (int s = 0; s < 3; s++) begin
        if (pos < n) begin
          p   = pos[1:0];
          len = u8dec_pkg::lead_length(buf_b[p]);
          if (len != 3'd0 && (pos + len) <= n) begin
            res[s].code_point = u8dec_pkg::assemble(buf_b[p], buf_b[p + 2'd1],
                                                    buf_b[p + 2'd2], buf_b[p + 2'd3], len);
            pos = pos + len;
          end else begin
            res[s].code_point  = u8dec_pkg::SUB_CHAR;
            res[s].substituted = 1'b1;
            pos = pos + 3'd1;
          end
          k = 2'(s + 1);
        end
      end
    end
    for (int s = 0; s < 3; s++) begin
      if (k == 2'(s + 1)) begin
        res[s].run_end  = 1'b1;
        res[s].text_end = item.final_byte;
      end
    end
    res_cnt = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      seq_len_r  <= 3'd0;
    end else if (commit) begin
      pend_cnt_r <= pend_cnt_nxt;
      seq_len_r  <= seq_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && hold) begin
      pend_bytes_r[pend_cnt_r] <= item.text_byte;
    end
  end

endmodule

FILE: hdl/u8dec_outq.sv
// shifting result queue; head entry drives the result channel
module u8dec_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [1:0]          push_cnt,
  input  u8dec_pkg::res_vec_t push_res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output u8dec_pkg::out_t     out_data
);

  u8dec_pkg::out_t q_r   [0:u8dec_pkg::QUEUE_DEP-1];
  u8dec_pkg::out_t q_nxt [0:u8dec_pkg::QUEUE_DEP-1];
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic [2:0] base;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - {2'd0, pop};

  // room is judged without the pop so ready does not depend on out_ready
  assign room = ({1'b0, cnt_r} + {2'd0, push_cnt}) <= 4'(u8dec_pkg::QUEUE_DEP);

  always_comb begin
    logic [2:0] off;
    off = 3'd0;
    for (int j = 0; j < u8dec_pkg::QUEUE_DEP; j++) begin
      if (pop && j < u8dec_pkg::QUEUE_DEP - 1) begin
        q_nxt[j] = q_r[j + 1];
      end else begin
        q_nxt[j] = q_r[j];
      end
      off = 3'(j) - base;
      if (push && 3'(j) >= base && off < {1'b0, push_cnt}) begin
        q_nxt[j] = push_res[off[1:0]];
      end
    end
    cnt_nxt = base + (push ? {1'b0, push_cnt} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < u8dec_pkg::QUEUE_DEP; j++) begin
      q_r[j] <= q_nxt[j];
    end
  end

endmodule
